// ===== rtl/ipa_pkg.sv =====
// Shared package for the indexed pool allocator.
// Holds field widths, operation and status codes, and the control structs
// passed between the controller and the datapath. No dependencies.
package ipa_pkg;

  localparam int unsigned POOL_SLOTS_DEF = 256;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_ALLOC      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE       = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WALK_RESET = 2'd2;
  localparam logic [MODE_W-1:0] MODE_WALK_STEP  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ENDED      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic issue;      // item accepted: latch it, launch table reads
    logic exec_fire;  // commit the first phase of the operation
    logic link_fire;  // commit the tail fix-up of an allocate
    logic load;       // capture the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic long_op;    // current item is an allocate that needs a second phase
  } sts_t;

endpackage

// ===== rtl/ipa_in_if.sv =====
// Request channel of the indexed pool allocator: valid/ready plus payload.
// Depends on ipa_pkg for field widths.
interface ipa_in_if;
  logic                          valid;
  logic                          ready;
  logic [ipa_pkg::MODE_W-1:0]    mode;
  logic [ipa_pkg::SLOT_W-1:0]    slot;

  modport source (output valid, output mode, output slot, input ready);
  modport sink   (input valid, input mode, input slot, output ready);
endinterface

// ===== rtl/ipa_out_if.sv =====
// Response channel of the indexed pool allocator: valid/ready plus payload.
// Depends on ipa_pkg for field widths.
interface ipa_out_if;
  logic                          valid;
  logic                          ready;
  logic [ipa_pkg::SLOT_W-1:0]    result_slot;
  logic [ipa_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output result_slot, output status, input ready);
  modport sink   (input valid, input result_slot, input status, output ready);
endinterface

// ===== rtl/ipa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module ipa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ipa_ctrl.sv =====
// Controller of the indexed pool allocator: sequences accept, execute and
// link phases and owns the output valid flag. Depends on ipa_pkg.
module ipa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ipa_pkg::sts_t sts_i,
  output ipa_pkg::cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LINK = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o.issue     = in_valid_i && (state_q == S_IDLE);
    cmd_o.exec_fire = (state_q == S_EXEC) && (sts_i.long_op || out_free);
    cmd_o.link_fire = (state_q == S_LINK) && out_free;
    cmd_o.load      = (cmd_o.exec_fire && !sts_i.long_op) || cmd_o.link_fire;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.issue) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_o.exec_fire) state_d = sts_i.long_op ? S_LINK : S_IDLE;
      end
      S_LINK: begin
        if (cmd_o.link_fire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // An accepted item always moves on to the execute phase.
  a_issue_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |=> state_q == S_EXEC)
    else $error("accepted item did not enter execute phase");

  // The link phase only follows an allocate that left the execute phase.
  a_link_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_LINK))
    else $error("link phase entered without an allocate");

  // A new result never overwrites one still waiting downstream.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while held");

  // A pending result is only raised by a load.
  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.load))
    else $error("output valid raised without a load");

endmodule

// ===== rtl/ipa_dp.sv =====
// Datapath of the indexed pool allocator: list registers, link tables,
// in-use table and result register. Depends on ipa_pkg and ipa_ram.
module ipa_dp #(
  parameter int unsigned POOL_SLOTS = ipa_pkg::POOL_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ipa_pkg::cmd_t                 cmd_i,
  output ipa_pkg::sts_t                 sts_o,
  input  logic [ipa_pkg::MODE_W-1:0]    in_mode_i,
  input  logic [ipa_pkg::SLOT_W-1:0]    in_slot_i,
  output logic [ipa_pkg::SLOT_W-1:0]    res_slot_o,
  output logic [ipa_pkg::STATUS_W-1:0]  res_status_o
);

  localparam int unsigned SW = $clog2(POOL_SLOTS);
  localparam int unsigned IW = $clog2(POOL_SLOTS + 2);
  localparam int unsigned CW = (IW > ipa_pkg::SLOT_W) ? IW : ipa_pkg::SLOT_W;

  localparam logic [IW-1:0] POOL_IDX = IW'(POOL_SLOTS);
  localparam logic [IW-1:0] HEAD_IDX = IW'(POOL_SLOTS);
  localparam logic [IW-1:0] TAIL_IDX = IW'(POOL_SLOTS + 1);

  function automatic logic [ipa_pkg::SLOT_W-1:0] low_byte(input logic [IW-1:0] v);
    logic [CW-1:0] t;
    t = CW'(v);
    return t[ipa_pkg::SLOT_W-1:0];
  endfunction

  // Latched item
  logic [ipa_pkg::MODE_W-1:0] mode_q;
  logic [CW-1:0]              slot_q;
  logic [CW-1:0]              slot_in;

  // List state
  logic [IW-1:0] spare_top_q, spare_top_d;
  logic [IW-1:0] last_q, last_d;
  logic [IW-1:0] cursor_q, cursor_d;
  logic [IW-1:0] head_next_q, head_next_d;
  logic [IW-1:0] hwm_q, hwm_d;

  // Allocate hand-off to the link phase
  logic [IW-1:0] lnk_last_q, lnk_last_d;
  logic [IW-1:0] lnk_after_q, lnk_after_d;
  logic [IW-1:0] lnk_idx_q, lnk_idx_d;

  // Result
  logic [ipa_pkg::SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic [ipa_pkg::STATUS_W-1:0] res_status_q, res_status_d;

  // Table ports
  logic          fs_we, pv_we, nx_we, us_we;
  logic [SW-1:0] fs_waddr, pv_waddr, nx_waddr, us_waddr;
  logic [IW-1:0] fs_wdata, pv_wdata, nx_wdata;
  logic          us_wdata;
  logic [SW-1:0] fs_raddr, pv_raddr, nx_raddr, us_raddr;
  logic [IW-1:0] fs_rdata, pv_rdata, nx_rdata;
  logic          us_rdata;

  // Decoded conditions
  logic          alloc_empty, alloc_fresh;
  logic [IW-1:0] alloc_after;
  logic          free_ok;
  logic [IW-1:0] free_idx;

  assign slot_in = CW'(in_slot_i);

  // Launch reads from the arriving item and current list registers
  always_comb begin
    fs_raddr = '0;
    pv_raddr = '0;
    nx_raddr = '0;
    us_raddr = '0;
    case (in_mode_i)
      ipa_pkg::MODE_ALLOC: begin
        fs_raddr = spare_top_q[SW-1:0];
        nx_raddr = last_q[SW-1:0];
      end
      ipa_pkg::MODE_FREE: begin
        pv_raddr = slot_in[SW-1:0];
        nx_raddr = slot_in[SW-1:0];
        us_raddr = slot_in[SW-1:0];
      end
      default: begin
        nx_raddr = cursor_q[SW-1:0];
        us_raddr = cursor_q[SW-1:0];
      end
    endcase
  end

  // Slots at or above the high-water mark were never taken: their free
  // successor is the next index and they are not in use.
  assign alloc_empty = (spare_top_q >= POOL_IDX);
  assign alloc_fresh = (spare_top_q >= hwm_q);
  assign alloc_after = (last_q == HEAD_IDX) ? head_next_q : nx_rdata;
  assign free_ok     = (slot_q < CW'(hwm_q)) && us_rdata;
  assign free_idx    = slot_q[IW-1:0];

  assign sts_o.long_op = (mode_q == ipa_pkg::MODE_ALLOC) && !alloc_empty;

  always_comb begin
    logic [IW-1:0] nxt;
    logic          walk_ok;

    nxt          = TAIL_IDX;
    walk_ok      = 1'b1;
    spare_top_d  = spare_top_q;
    last_d       = last_q;
    cursor_d     = cursor_q;
    head_next_d  = head_next_q;
    hwm_d        = hwm_q;
    lnk_last_d   = lnk_last_q;
    lnk_after_d  = lnk_after_q;
    lnk_idx_d    = lnk_idx_q;
    res_slot_d   = '0;
    res_status_d = ipa_pkg::ST_OK;
    fs_we = 1'b0; fs_waddr = '0; fs_wdata = '0;
    pv_we = 1'b0; pv_waddr = '0; pv_wdata = '0;
    nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0;
    us_we = 1'b0; us_waddr = '0; us_wdata = 1'b0;

    if (cmd_i.exec_fire) begin
      case (mode_q)
        ipa_pkg::MODE_ALLOC: begin
          if (alloc_empty) begin
            res_status_d = ipa_pkg::ST_EMPTY;
          end else begin
            pv_we = 1'b1; pv_waddr = spare_top_q[SW-1:0]; pv_wdata = last_q;
            nx_we = 1'b1; nx_waddr = spare_top_q[SW-1:0]; nx_wdata = alloc_after;
            us_we = 1'b1; us_waddr = spare_top_q[SW-1:0]; us_wdata = 1'b1;
            spare_top_d = alloc_fresh ? spare_top_q + IW'(1) : fs_rdata;
            if (alloc_fresh) hwm_d = spare_top_q + IW'(1);
            last_d      = spare_top_q;
            lnk_last_d  = last_q;
            lnk_after_d = alloc_after;
            lnk_idx_d   = spare_top_q;
          end
        end
        ipa_pkg::MODE_FREE: begin
          if (!free_ok) begin
            res_status_d = ipa_pkg::ST_NOT_IN_USE;
          end else begin
            if (pv_rdata == HEAD_IDX) begin
              head_next_d = nx_rdata;
            end else begin
              nx_we = 1'b1; nx_waddr = pv_rdata[SW-1:0]; nx_wdata = nx_rdata;
            end
            if (nx_rdata < POOL_IDX) begin
              pv_we = 1'b1; pv_waddr = nx_rdata[SW-1:0]; pv_wdata = pv_rdata;
            end
            if (last_q == free_idx) last_d = pv_rdata;
            fs_we = 1'b1; fs_waddr = free_idx[SW-1:0]; fs_wdata = spare_top_q;
            us_we = 1'b1; us_waddr = free_idx[SW-1:0]; us_wdata = 1'b0;
            spare_top_d = free_idx;
          end
        end
        ipa_pkg::MODE_WALK_RESET: begin
          cursor_d = HEAD_IDX;
        end
        ipa_pkg::MODE_WALK_STEP: begin
          if (cursor_q == TAIL_IDX) begin
            walk_ok = 1'b0;
          end else if (cursor_q == HEAD_IDX) begin
            nxt = head_next_q;
          end else if (!((cursor_q < hwm_q) && us_rdata)) begin
            walk_ok = 1'b0;
          end else begin
            nxt = nx_rdata;
          end
          if (nxt >= POOL_IDX) walk_ok = 1'b0;
          if (walk_ok) begin
            cursor_d   = nxt;
            res_slot_d = low_byte(nxt);
          end else begin
            cursor_d     = TAIL_IDX;
            res_status_d = ipa_pkg::ST_ENDED;
          end
        end
        default: begin
          res_status_d = ipa_pkg::ST_OK;
        end
      endcase
    end

    // Hook the new slot in behind the old last one
    if (cmd_i.link_fire) begin
      if (lnk_last_q == HEAD_IDX) begin
        head_next_d = lnk_idx_q;
      end else begin
        nx_we = 1'b1; nx_waddr = lnk_last_q[SW-1:0]; nx_wdata = lnk_idx_q;
      end
      if (lnk_after_q < POOL_IDX) begin
        pv_we = 1'b1; pv_waddr = lnk_after_q[SW-1:0]; pv_wdata = lnk_idx_q;
      end
      res_slot_d = low_byte(lnk_idx_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spare_top_q <= '0;
      last_q      <= HEAD_IDX;
      cursor_q    <= HEAD_IDX;
      head_next_q <= TAIL_IDX;
      hwm_q       <= '0;
    end else begin
      spare_top_q <= spare_top_d;
      last_q      <= last_d;
      cursor_q    <= cursor_d;
      head_next_q <= head_next_d;
      hwm_q       <= hwm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      mode_q <= in_mode_i;
      slot_q <= slot_in;
    end
    lnk_last_q  <= lnk_last_d;
    lnk_after_q <= lnk_after_d;
    lnk_idx_q   <= lnk_idx_d;
    if (cmd_i.load) begin
      res_slot_q   <= res_slot_d;
      res_status_q <= res_status_d;
    end
  end

  assign res_slot_o   = res_slot_q;
  assign res_status_o = res_status_q;

  ipa_ram #(.WIDTH(IW), .DEPTH(POOL_SLOTS)) u_free_succ (
    .clk_i, .we_i(fs_we), .waddr_i(fs_waddr), .wdata_i(fs_wdata),
    .re_i(cmd_i.issue), .raddr_i(fs_raddr), .rdata_o(fs_rdata)
  );

  ipa_ram #(.WIDTH(IW), .DEPTH(POOL_SLOTS)) u_prev_link (
    .clk_i, .we_i(pv_we), .waddr_i(pv_waddr), .wdata_i(pv_wdata),
    .re_i(cmd_i.issue), .raddr_i(pv_raddr), .rdata_o(pv_rdata)
  );

  ipa_ram #(.WIDTH(IW), .DEPTH(POOL_SLOTS)) u_next_link (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .re_i(cmd_i.issue), .raddr_i(nx_raddr), .rdata_o(nx_rdata)
  );

  ipa_ram #(.WIDTH(1), .DEPTH(POOL_SLOTS)) u_in_use (
    .clk_i, .we_i(us_we), .waddr_i(us_waddr), .wdata_i(us_wdata),
    .re_i(cmd_i.issue), .raddr_i(us_raddr), .rdata_o(us_rdata)
  );

endmodule

// ===== rtl/indexed_pool_allocator_top.sv =====
// Top level of the indexed pool allocator: request and response channels,
// controller and datapath. Depends on ipa_pkg, ipa_in_if, ipa_out_if,
// ipa_ctrl and ipa_dp.

// The block manages POOL_SLOTS slots. Free slots sit on a singly linked free
// list; slots in use sit on a doubly linked active list in allocation order,
// between a head and a tail sentinel. Each request item carries a mode
// (allocate, free slot, reset iterator, step iterator) and a slot number, and
// produces exactly one response item with a result slot and a status (ok,
// pool empty, iteration ended, slot not in use). One item is in flight at a
// time: an allocate that finds a free slot holds the block for accept and
// table read, link-in of the new slot and fix-up behind the old last slot,
// and its result is loaded at the fix-up; every other item holds it for
// accept and table read and then commit, and its result is loaded at the
// commit. The phases are set by the registered read of the link tables and
// by the two writes an allocate makes into the next-link table. The result
// sits in an output register, so the next item is taken while a response
// still waits; only the final commit of that next item holds until the
// response is taken. The tables need no clearing after reset: a high-water
// mark of slots ever handed out stands in for the reset contents, so the
// block is ready right out of reset.
module indexed_pool_allocator_top #(
  parameter int unsigned POOL_SLOTS = ipa_pkg::POOL_SLOTS_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  ipa_in_if.sink   req_i,
  ipa_out_if.source rsp_o
);

  ipa_pkg::cmd_t cmd;
  ipa_pkg::sts_t sts;

  logic in_ready;
  logic out_valid;
  logic [ipa_pkg::SLOT_W-1:0]   res_slot;
  logic [ipa_pkg::STATUS_W-1:0] res_status;

  // Sequence the phases of each item and hold the response valid
  ipa_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Keep the lists, the tables and the response payload
  ipa_dp #(.POOL_SLOTS(POOL_SLOTS)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_mode_i    (req_i.mode),
    .in_slot_i    (req_i.slot),
    .res_slot_o   (res_slot),
    .res_status_o (res_status)
  );

  assign req_i.ready       = in_ready;
  assign rsp_o.valid       = out_valid;
  assign rsp_o.result_slot = res_slot;
  assign rsp_o.status      = res_status;

endmodule

// ===== dv/indexed_pool_allocator_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for indexed_pool_allocator_top: slot allocate, free and
// active-list walks, checked item by item against a mirror of the pool.
// Depends on ipa_pkg, ipa_in_if, ipa_out_if and the RTL of the block.
module indexed_pool_allocator_top_tb;

  localparam int unsigned SLOTS         = ipa_pkg::POOL_SLOTS_DEF;
  localparam int unsigned HEAD_SENT     = SLOTS;
  localparam int unsigned TAIL_SENT     = SLOTS + 1;
  localparam int unsigned LINK_CNT      = SLOTS + 2;
  localparam int unsigned PHASE_ITEMS   = 370;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef logic [8:0]                   link_t;
  typedef logic [ipa_pkg::MODE_W-1:0]   mode_t;
  typedef logic [ipa_pkg::SLOT_W-1:0]   slot_t;
  typedef logic [ipa_pkg::STATUS_W-1:0] status_t;

  typedef struct packed {
    slot_t   slot;
    status_t status;
  } pool_result_t;

  // One row of the opening sequence; typed rows carry their answer, the rest
  // take the answer from the pool mirror.
  typedef struct packed {
    mode_t        mode;
    slot_t        slot;
    logic         typed;
    pool_result_t want;
  } opening_op_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ipa_in_if  req_if ();
  ipa_out_if rsp_if ();

  indexed_pool_allocator_top #(
    .POOL_SLOTS(SLOTS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mirror of the pool: free list, active list links, ownership bits, walker.
  link_t       free_succ [SLOTS];
  link_t       prev_lk   [LINK_CNT];
  link_t       next_lk   [LINK_CNT];
  bit          in_use    [SLOTS];
  link_t       last_active;
  link_t       spare_top;
  link_t       walk_cursor;
  int unsigned active_count;

  pool_result_t awaited_results [$];
  pool_result_t head_result;

  int unsigned items_sent;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  int unsigned idle_by_phase  [4] = '{0, 79, 0, 12};
  int unsigned stall_by_phase [4] = '{0, 0, 79, 12};

  // Opening sequence: empty walk, frees of slots never handed out, LIFO reuse
  // of the free list, a full walk past the end, a walk whose slot gets freed
  // under the cursor, and unlinks at the last and first positions.
  opening_op_t opening_ops [25] = '{
    '{ipa_pkg::MODE_WALK_STEP,  8'd0,   1'b1, '{8'd0, ipa_pkg::ST_ENDED}},
    '{ipa_pkg::MODE_WALK_RESET, 8'd0,   1'b1, '{8'd0, ipa_pkg::ST_OK}},
    '{ipa_pkg::MODE_FREE,       8'd0,   1'b1, '{8'd0, ipa_pkg::ST_NOT_IN_USE}},
    '{ipa_pkg::MODE_FREE,       8'd255, 1'b1, '{8'd0, ipa_pkg::ST_NOT_IN_USE}},
    '{ipa_pkg::MODE_ALLOC,      8'd255, 1'b1, '{8'd0, ipa_pkg::ST_OK}},
    '{ipa_pkg::MODE_ALLOC,      8'd0,   1'b1, '{8'd1, ipa_pkg::ST_OK}},
    '{ipa_pkg::MODE_ALLOC,      8'd170, 1'b1, '{8'd2, ipa_pkg::ST_OK}},
    '{ipa_pkg::MODE_FREE,       8'd1,   1'b1, '{8'd0, ipa_pkg::ST_OK}},
    '{ipa_pkg::MODE_FREE,       8'd1,   1'b1, '{8'd0, ipa_pkg::ST_NOT_IN_USE}},
    '{ipa_pkg::MODE_ALLOC,      8'd85,  1'b0, '{8'd0, ipa_pkg::ST_OK}},
    '{ipa_pkg::MODE_WALK_RESET, 8'd255, 1'b1, '{8'd0, ipa_pkg::ST_OK}},
    '{ipa_pkg::MODE_WALK_STEP,  8'd0,   1'b0, '{8'd0, ipa_pkg::ST_OK}},
    '{ipa_pkg::MODE_WALK_STEP,  8'd0,   1'b0, '{8'd0, ipa_pkg::ST_OK}},
    '{ipa_pkg::MODE_WALK_STEP,  8'd0,   1'b0, '{8'd0, ipa_pkg::ST_OK}},
    '{ipa_pkg::MODE_WALK_STEP,  8'd0,   1'b1, '{8'd0, ipa_pkg::ST_ENDED}},
    '{ipa_pkg::MODE_WALK_STEP,  8'd255, 1'b1, '{8'd0, ipa_pkg::ST_ENDED}},
    '{ipa_pkg::MODE_WALK_RESET, 8'd0,   1'b1, '{8'd0, ipa_pkg::ST_OK}},
    '{ipa_pkg::MODE_WALK_STEP,  8'd0,   1'b0, '{8'd0, ipa_pkg::ST_OK}},
    '{ipa_pkg::MODE_FREE,       8'd0,   1'b1, '{8'd0, ipa_pkg::ST_OK}},
    '{ipa_pkg::MODE_WALK_STEP,  8'd0,   1'b1, '{8'd0, ipa_pkg::ST_ENDED}},
    '{ipa_pkg::MODE_FREE,       8'd1,   1'b1, '{8'd0, ipa_pkg::ST_OK}},
    '{ipa_pkg::MODE_ALLOC,      8'd0,   1'b0, '{8'd0, ipa_pkg::ST_OK}},
    '{ipa_pkg::MODE_ALLOC,      8'd0,   1'b0, '{8'd0, ipa_pkg::ST_OK}},
    '{ipa_pkg::MODE_FREE,       8'd2,   1'b1, '{8'd0, ipa_pkg::ST_OK}},
    '{ipa_pkg::MODE_ALLOC,      8'd0,   1'b0, '{8'd0, ipa_pkg::ST_OK}}
  };

  // Out-of-range link values fall onto the tail sentinel.
  function automatic link_t to_node(link_t x);
    return (x < LINK_CNT) ? x : link_t'(TAIL_SENT);
  endfunction

  function automatic void pool_reset();
    for (int unsigned i = 0; i < SLOTS; i++) begin
      free_succ[i] = link_t'(i + 1);
      in_use[i]    = 1'b0;
    end
    for (int unsigned i = 0; i < LINK_CNT; i++) begin
      prev_lk[i] = '0;
      next_lk[i] = '0;
    end
    next_lk[HEAD_SENT] = link_t'(TAIL_SENT);
    prev_lk[TAIL_SENT] = link_t'(HEAD_SENT);
    last_active  = link_t'(HEAD_SENT);
    spare_top    = '0;
    walk_cursor  = link_t'(HEAD_SENT);
    active_count = 0;
  endfunction

  // Apply one item to the mirror and return the answer the block owes.
  function automatic pool_result_t pool_apply(mode_t mode, slot_t slot);
    link_t        idx, last, after, prior, cur, nxt;
    pool_result_t res;
    res.slot   = '0;
    res.status = ipa_pkg::ST_OK;
    case (mode)
      ipa_pkg::MODE_ALLOC: begin
        idx = spare_top;
        if (idx >= SLOTS) begin
          res.status = ipa_pkg::ST_EMPTY;
        end else begin
          last  = to_node(last_active);
          after = to_node(next_lk[last]);
          prev_lk[idx]   = last;
          next_lk[idx]   = after;
          next_lk[last]  = idx;
          prev_lk[after] = idx;
          last_active    = idx;
          spare_top      = free_succ[idx];
          in_use[idx]    = 1'b1;
          active_count++;
          res.slot = idx[ipa_pkg::SLOT_W-1:0];
        end
      end
      ipa_pkg::MODE_FREE: begin
        if (slot >= SLOTS || !in_use[slot]) begin
          res.status = ipa_pkg::ST_NOT_IN_USE;
        end else begin
          prior = to_node(prev_lk[slot]);
          after = to_node(next_lk[slot]);
          next_lk[prior] = after;
          prev_lk[after] = prior;
          if (last_active == slot) last_active = prior;
          free_succ[slot] = spare_top;
          spare_top       = link_t'(slot);
          in_use[slot]    = 1'b0;
          active_count--;
        end
      end
      ipa_pkg::MODE_WALK_RESET: begin
        walk_cursor = link_t'(HEAD_SENT);
      end
      default: begin
        cur = to_node(walk_cursor);
        if (cur < SLOTS && !in_use[cur]) begin
          // the slot under the cursor was freed: the walk is over
          walk_cursor = link_t'(TAIL_SENT);
          res.status  = ipa_pkg::ST_ENDED;
        end else begin
          nxt = (cur == TAIL_SENT) ? link_t'(TAIL_SENT) : to_node(next_lk[cur]);
          if (nxt >= SLOTS) begin
            walk_cursor = link_t'(TAIL_SENT);
            res.status  = ipa_pkg::ST_ENDED;
          end else begin
            walk_cursor = nxt;
            res.slot    = nxt[ipa_pkg::SLOT_W-1:0];
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic slot_t rand_slot();
    return slot_t'($urandom_range(SLOTS - 1));
  endfunction

  // First slot in use at or after start, wrapping; start itself if none.
  function automatic slot_t pick_active(slot_t start);
    int unsigned k;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      k = (start + i) % SLOTS;
      if (in_use[k]) return slot_t'(k);
    end
    return start;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Offer one item, hold it until taken, then log what the block owes for it.
  task automatic send_item(input mode_t mode, input slot_t slot,
                           input logic typed, input pool_result_t want);
    pool_result_t seen;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.mode  <= mode;
    req_if.slot  <= slot;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    seen = pool_apply(mode, slot);
    awaited_results.push_back(typed ? want : seen);
    items_sent++;
  endtask

  // Hold the request side quiet until every owed result has come back.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  // Walk the active list, now and then freeing a slot along the way,
  // often the one under the cursor.
  task automatic run_walk();
    int unsigned steps;
    slot_t       victim;
    if ($urandom_range(99) < 80) send_item(ipa_pkg::MODE_WALK_RESET, rand_slot(), 1'b0, '0);
    steps = ($urandom_range(9) == 0) ? active_count + 2 : $urandom_range(20, 1);
    repeat (steps) begin
      send_item(ipa_pkg::MODE_WALK_STEP, rand_slot(), 1'b0, '0);
      if ($urandom_range(99) < 12) begin
        victim = (walk_cursor < SLOTS && $urandom_range(1) == 1) ?
                 walk_cursor[ipa_pkg::SLOT_W-1:0] : pick_active(rand_slot());
        send_item(ipa_pkg::MODE_FREE, victim, 1'b0, '0);
      end
    end
  endtask

  // Random traffic in sessions, each steering the pool toward a fill level:
  // empty, full (and past it), or somewhere between. A few items are noise.
  task automatic run_random(input int unsigned count, input bit fill_first);
    int unsigned stop_at, session_end, target, r;
    bit          grow;
    slot_t       s;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(4))
        0:       target = 0;
        1:       target = SLOTS;
        default: target = $urandom_range(SLOTS - 1, 1);
      endcase
      if (fill_first) target = SLOTS;
      fill_first  = 1'b0;
      session_end = items_sent + ((target == SLOTS) ? 380 : $urandom_range(120, 40));
      while (items_sent < session_end && items_sent < stop_at) begin
        r = $urandom_range(99);
        s = rand_slot();
        if (r < 6) begin
          run_walk();
        end else if (r < 11) begin
          send_item(ipa_pkg::MODE_FREE, s, 1'b0, '0);
        end else begin
          grow = (target == SLOTS) || (active_count < target);
          if ($urandom_range(99) < 7) grow = !grow;
          if (grow) send_item(ipa_pkg::MODE_ALLOC, s, 1'b0, '0);
          else      send_item(ipa_pkg::MODE_FREE, pick_active(s), 1'b0, '0);
        end
        if ($urandom_range(299) == 0) drain_results();
      end
    end
  endtask

  // Result side: check each taken item against the oldest owed answer, keep
  // the no-progress count, and toss the ready for the next edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result slot %0d status %0d with nothing owed",
                                    rsp_if.result_slot, rsp_if.status));
        end else begin
          head_result = awaited_results.pop_front();
          if (rsp_if.result_slot !== head_result.slot)
            report_mismatch($sformatf("result_slot %0d, want %0d",
                                      rsp_if.result_slot, head_result.slot));
          if (rsp_if.status !== head_result.status)
            report_mismatch($sformatf("status %0d, want %0d",
                                      rsp_if.status, head_result.status));
        end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end else begin
      rsp_if.ready <= 1'b0;
    end
  end

  // Drop the run if nothing moves on either side for too long.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("indexed_pool_allocator_top regression: fail");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    req_if.valid  <= 1'b0;
    req_if.mode   <= ipa_pkg::MODE_ALLOC;
    req_if.slot   <= '0;
    items_sent     = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    pool_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phases: no idling, sender idling, receiver stalling, both a little.
    for (int unsigned p = 0; p < 4; p++) begin
      send_idle_pct = idle_by_phase[p];
      stall_pct     = stall_by_phase[p];
      if (p == 0) begin
        foreach (opening_ops[i])
          send_item(opening_ops[i].mode, opening_ops[i].slot,
                    opening_ops[i].typed, opening_ops[i].want);
      end
      run_random(PHASE_ITEMS, p == 0);
      drain_results();
    end

    // Let any stray result show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_results.size() == 0)
      $display("indexed_pool_allocator_top regression: pass");
    else
      $display("indexed_pool_allocator_top regression: fail");
    $finish;
  end

endmodule

// ===== indexed_pool_allocator_top.f =====
rtl/ipa_pkg.sv
rtl/ipa_in_if.sv
rtl/ipa_out_if.sv
rtl/ipa_ram.sv
rtl/ipa_ctrl.sv
rtl/ipa_dp.sv
rtl/indexed_pool_allocator_top.sv
dv/indexed_pool_allocator_top_tb.sv
